// ===== hw/rtl/mhg_pkg.sv =====
// ----------------------------------------------------------------------------
// mhg_pkg
// Shared types, codes and constants of the move history tables with gravity.
// ----------------------------------------------------------------------------
package mhg_pkg;

  // Item kinds
  typedef enum logic [2:0] {
    KIND_QUIET_BONUS = 3'd0,
    KIND_QUIET_MALUS = 3'd1,
    KIND_CAPT_BONUS  = 3'd2,
    KIND_CAPT_MALUS  = 3'd3,
    KIND_QUIET_READ  = 3'd4
  } kind_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 23;

  localparam logic [CFG_INDEX_W-1:0] CFG_BONUS_SHIFT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRAVITY_SHIFT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BONUS_BASE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MALUS_BASE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_LIMIT   = 3'd4;

  // Configuration reset values
  localparam logic [3:0]  RST_BONUS_SHIFT   = 4'd4;
  localparam logic [4:0]  RST_GRAVITY_SHIFT = 5'd14;
  localparam logic [11:0] RST_BONUS_BASE    = 12'd0;
  localparam logic [11:0] RST_MALUS_BASE    = 12'd0;
  localparam logic [22:0] RST_ENTRY_LIMIT   = 23'd16384;

  // Weight and result widths; a malus can reach -2048 - 127
  localparam int WGT_W     = 13;
  localparam int OUT_W     = 24;
  localparam int BONUS_CAP = 500;

  // Settings the update unit needs for one item
  typedef struct packed {
    logic [3:0]  bonus_shift;
    logic [4:0]  gravity_shift;
    logic [22:0] entry_limit;
  } cfg_t;

  // Table select and memory request
  typedef enum logic [1:0] {
    TBL_MAIN = 2'd0,
    TBL_CAPT = 2'd1,
    TBL_CONT = 2'd2
  } tbl_t;

  typedef struct packed {
    logic rd;
    logic wr;
    tbl_t sel;
  } mem_req_t;

  // Reduce a small value modulo m by conditional subtraction; the inputs
  // stay below four times the modulus.
  function automatic logic [8:0] reduce(input logic [8:0] v, input logic [8:0] m);
    logic [8:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (r >= m) r = r - m;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mhg_tables.sv =====
// ----------------------------------------------------------------------------
// mhg_tables
// Main, capture and continuation score memories behind one request port,
// with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module mhg_tables #(
  parameter int MAIN_DEPTH = 8192,
  parameter int CAPT_DEPTH = 4608,
  parameter int CONT_DEPTH = 294912,
  parameter int ENTRY_BITS = 24,
  parameter int ADDR_W     = 19
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mhg_pkg::mem_req_t     req,
  input  logic [ADDR_W-1:0]     addr,
  input  logic [ENTRY_BITS-1:0] wdata,
  output logic [ENTRY_BITS-1:0] rdata,
  output logic                  ready
);

  localparam int MAIN_AW = $clog2(MAIN_DEPTH);
  localparam int CAPT_AW = $clog2(CAPT_DEPTH);
  localparam int CONT_AW = $clog2(CONT_DEPTH);

  logic [ENTRY_BITS-1:0] main_mem [MAIN_DEPTH];
  logic [ENTRY_BITS-1:0] capt_mem [CAPT_DEPTH];
  logic [ENTRY_BITS-1:0] cont_mem [CONT_DEPTH];

  logic [ADDR_W-1:0]     clr_addr;
  logic                  clr_busy;
  logic                  main_we, capt_we, cont_we;
  logic [MAIN_AW-1:0]    main_wa;
  logic [CAPT_AW-1:0]    capt_wa;
  logic [CONT_AW-1:0]    cont_wa;
  logic [ENTRY_BITS-1:0] wd;
  logic [ENTRY_BITS-1:0] main_q, capt_q, cont_q;
  mhg_pkg::tbl_t         sel_q;

  // Clearing sweep, one entry of each table per cycle while the address is within its depth
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_busy <= 1'b1;
    end else if (clr_busy) begin
      if (clr_addr == ADDR_W'(CONT_DEPTH - 1)) clr_busy <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign ready = !clr_busy;

  // Write port muxing between sweep and requests
  always_comb begin
    if (clr_busy) begin
      main_we = clr_addr < ADDR_W'(MAIN_DEPTH);
      capt_we = clr_addr < ADDR_W'(CAPT_DEPTH);
      cont_we = 1'b1;
      main_wa = clr_addr[MAIN_AW-1:0];
      capt_wa = clr_addr[CAPT_AW-1:0];
      cont_wa = clr_addr[CONT_AW-1:0];
      wd      = '0;
    end else begin
      main_we = req.wr && (req.sel == mhg_pkg::TBL_MAIN);
      capt_we = req.wr && (req.sel == mhg_pkg::TBL_CAPT);
      cont_we = req.wr && (req.sel == mhg_pkg::TBL_CONT);
      main_wa = addr[MAIN_AW-1:0];
      capt_wa = addr[CAPT_AW-1:0];
      cont_wa = addr[CONT_AW-1:0];
      wd      = wdata;
    end
  end

  // Main table
  always_ff @(posedge clk) begin
    if (main_we) main_mem[main_wa] <= wd;
    if (req.rd && (req.sel == mhg_pkg::TBL_MAIN)) main_q <= main_mem[addr[MAIN_AW-1:0]];
  end

  // Capture table
  always_ff @(posedge clk) begin
    if (capt_we) capt_mem[capt_wa] <= wd;
    if (req.rd && (req.sel == mhg_pkg::TBL_CAPT)) capt_q <= capt_mem[addr[CAPT_AW-1:0]];
  end

  // Continuation table
  always_ff @(posedge clk) begin
    if (cont_we) cont_mem[cont_wa] <= wd;
    if (req.rd && (req.sel == mhg_pkg::TBL_CONT)) cont_q <= cont_mem[addr[CONT_AW-1:0]];
  end

  // Remember which table the last read went to
  always_ff @(posedge clk) begin
    if (req.rd) sel_q <= req.sel;
  end

  always_comb begin
    unique case (sel_q)
      mhg_pkg::TBL_MAIN: rdata = main_q;
      mhg_pkg::TBL_CAPT: rdata = capt_q;
      default:           rdata = cont_q;
    endcase
  end

endmodule

// ===== hw/rtl/mhg_update.sv =====
// ----------------------------------------------------------------------------
// mhg_update
// Shared three-stage gravity update: entry + (weight << shift)
// - trunc(entry * |weight| / 2^gravity), clamped to the entry limit.
// ----------------------------------------------------------------------------
module mhg_update #(
  parameter int ENTRY_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [ENTRY_BITS-1:0] entry,
  input  logic signed [mhg_pkg::WGT_W-1:0] weight,
  input  mhg_pkg::cfg_t                cfg,
  output logic                         out_valid,
  output logic signed [ENTRY_BITS-1:0] result
);

  localparam int UPROD_W = ENTRY_BITS + mhg_pkg::WGT_W - 1;
  localparam int SUM_W   = UPROD_W + 2;
  localparam logic signed [SUM_W-1:0] CAP = SUM_W'((64'd1 << (ENTRY_BITS - 1)) - 64'd1);

  logic                         v1, v2;
  logic [ENTRY_BITS-1:0]        mag_e;
  logic [mhg_pkg::WGT_W-1:0]    mag_w;
  logic [UPROD_W-1:0]           uprod1;
  logic                         neg1;
  logic signed [ENTRY_BITS-1:0] e1;
  logic signed [SUM_W-1:0]      wsh1;
  logic [UPROD_W-1:0]           qmag;
  logic signed [SUM_W-1:0]      q2, base2;
  logic signed [SUM_W-1:0]      sum, lim, res;

  // Stage 1: magnitudes and product
  assign mag_e = entry[ENTRY_BITS-1] ? ENTRY_BITS'(-entry) : ENTRY_BITS'(entry);
  assign mag_w = weight[mhg_pkg::WGT_W-1] ? mhg_pkg::WGT_W'(-weight)
                                          : mhg_pkg::WGT_W'(weight);

  always_ff @(posedge clk) begin
    uprod1 <= UPROD_W'(mag_e) * UPROD_W'(mag_w[mhg_pkg::WGT_W-2:0]);
    neg1   <= entry[ENTRY_BITS-1];
    e1     <= entry;
    wsh1   <= SUM_W'(weight) <<< cfg.bonus_shift;
  end

  // Stage 2: truncating divide by power of two, signed back; base sum
  assign qmag = uprod1 >> cfg.gravity_shift;

  always_ff @(posedge clk) begin
    q2    <= neg1 ? -signed'(SUM_W'(qmag)) : signed'(SUM_W'(qmag));
    base2 <= SUM_W'(e1) + wsh1;
  end

  // Stage 3: subtract and clamp
  always_comb begin
    sum = base2 - q2;
    lim = (SUM_W'(cfg.entry_limit) > CAP) ? CAP : signed'(SUM_W'(cfg.entry_limit));
    if (sum > lim) res = lim;
    else if (sum < -lim) res = -lim;
    else res = sum;
  end

  always_ff @(posedge clk) begin
    result <= ENTRY_BITS'(res);
  end

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

// ===== hw/rtl/move_history_gravity_tables.sv =====
// ----------------------------------------------------------------------------
// move_history_gravity_tables
// Main, capture and continuation move history with gravity updates.
// ----------------------------------------------------------------------------
// After reset the block sweeps all tables to zero over 2*PIECE_TYPES^2*SQUARES^2
// addresses (294912 at the default sizes) with busy high, and busy drops in the
// cycle after the sweep ends; configuration writes are taken throughout. An item
// is taken when start is high and busy is low. The item then walks its table
// entries one at a time (main followed by the one-ply and two-ply continuation
// entries when present, or capture alone) through a single memory port and one
// shared three-stage update unit: an updated entry passes through read, data and
// the three unit stages with write-back, a read-only entry through read and
// data. An item has one to three entries. The result is shown on the value
// ports for the single cycle that done is high and must be taken then; busy
// is already low in that cycle, so the next item may start there.
// ----------------------------------------------------------------------------
module move_history_gravity_tables #(
  parameter int SQUARES     = 64,
  parameter int PIECE_TYPES = 6,
  parameter int ENTRY_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [mhg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mhg_pkg::CFG_DATA_W-1:0]      cfg_data,
  // command
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          kind,
  input  logic                                side,
  input  logic [5:0]                          from_sq,
  input  logic [5:0]                          to_sq,
  input  logic [2:0]                          piece,
  input  logic [2:0]                          victim,
  input  logic [6:0]                          depth,
  input  logic [2:0]                          prev1_piece,
  input  logic [5:0]                          prev1_to,
  input  logic [2:0]                          prev2_piece,
  input  logic [5:0]                          prev2_to,
  // result
  output logic                                done,
  output logic signed [mhg_pkg::OUT_W-1:0]    main_value,
  output logic signed [mhg_pkg::OUT_W-1:0]    cont1_value,
  output logic signed [mhg_pkg::OUT_W-1:0]    cont2_value
);

  localparam int MAIN_DEPTH = 2 * SQUARES * SQUARES;
  localparam int CAPT_DEPTH = 2 * PIECE_TYPES * SQUARES * PIECE_TYPES;
  localparam int CONT_DEPTH = PIECE_TYPES * SQUARES * PIECE_TYPES * SQUARES * 2;
  localparam int ADDR_W     = $clog2(CONT_DEPTH);
  localparam int OUT_W      = mhg_pkg::OUT_W;
  localparam int WGT_W      = mhg_pkg::WGT_W;

  localparam logic [ADDR_W-1:0] SQ_A   = ADDR_W'(SQUARES);
  localparam logic [ADDR_W-1:0] PT_A   = ADDR_W'(PIECE_TYPES);
  localparam logic [8:0]        SQ_M   = 9'(SQUARES);
  localparam logic [8:0]        PT_M   = 9'(PIECE_TYPES);
  localparam logic [4:0]        PT_LIM = 5'(PIECE_TYPES);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_ADDR, S_READ, S_DATA, S_CALC} state_t;
  typedef enum logic [1:0] {STEP_MAIN, STEP_CONT1, STEP_CONT2} step_t;

  // Configuration registers
  logic [3:0]         bonus_shift;
  logic [4:0]         gravity_shift;
  logic signed [11:0] bonus_base;
  logic signed [11:0] malus_base;
  logic [22:0]        entry_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      bonus_shift   <= mhg_pkg::RST_BONUS_SHIFT;
      gravity_shift <= mhg_pkg::RST_GRAVITY_SHIFT;
      bonus_base    <= signed'(mhg_pkg::RST_BONUS_BASE);
      malus_base    <= signed'(mhg_pkg::RST_MALUS_BASE);
      entry_limit   <= mhg_pkg::RST_ENTRY_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mhg_pkg::CFG_BONUS_SHIFT:   bonus_shift   <= cfg_data[3:0];
        mhg_pkg::CFG_GRAVITY_SHIFT: gravity_shift <= cfg_data[4:0];
        mhg_pkg::CFG_BONUS_BASE:    bonus_base    <= signed'(cfg_data[11:0]);
        mhg_pkg::CFG_MALUS_BASE:    malus_base    <= signed'(cfg_data[11:0]);
        mhg_pkg::CFG_ENTRY_LIMIT:   entry_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and latched item
  state_t             state;
  step_t              step;
  logic               capt_q, upd_q, bonus_q, has1_q, has2_q;
  logic               side_q;
  logic [5:0]         from_q, to_q, t1_q, t2_q;
  logic [2:0]         pc_q, vc_q, p1_q, p2_q;
  logic [6:0]         depth_q;
  logic [ADDR_W-1:0]  main_addr, capt_addr, cont1_addr, cont2_addr;
  logic signed [WGT_W-1:0] weight_q;

  // Decode of the incoming kind
  logic dec_capt, dec_upd, dec_bonus;

  always_comb begin
    dec_capt  = 1'b0;
    dec_upd   = 1'b0;
    dec_bonus = 1'b0;
    unique case (kind)
      mhg_pkg::KIND_QUIET_BONUS: begin
        dec_upd   = 1'b1;
        dec_bonus = 1'b1;
      end
      mhg_pkg::KIND_QUIET_MALUS: dec_upd = 1'b1;
      mhg_pkg::KIND_CAPT_BONUS: begin
        dec_capt  = 1'b1;
        dec_upd   = 1'b1;
        dec_bonus = 1'b1;
      end
      mhg_pkg::KIND_CAPT_MALUS: begin
        dec_capt = 1'b1;
        dec_upd  = 1'b1;
      end
      default: ; // quiet read; unused codes read too
    endcase
  end

  // Address and weight computation from the latched item
  logic [ADDR_W-1:0]  main_addr_c, capt_addr_c, cont1_addr_c, cont2_addr_c;
  logic [13:0]        dsq;
  logic signed [15:0] bonus_c, bonus_lim, malus_c;

  always_comb begin
    main_addr_c  = (ADDR_W'(side_q) * SQ_A + ADDR_W'(from_q)) * SQ_A + ADDR_W'(to_q);
    capt_addr_c  = ((ADDR_W'(side_q) * PT_A + ADDR_W'(pc_q)) * SQ_A + ADDR_W'(to_q)) * PT_A
                   + ADDR_W'(vc_q);
    cont1_addr_c = ((((ADDR_W'(p1_q) * SQ_A + ADDR_W'(t1_q)) * PT_A + ADDR_W'(pc_q)) * SQ_A
                   + ADDR_W'(to_q)) << 1);
    cont2_addr_c = ((((ADDR_W'(p2_q) * SQ_A + ADDR_W'(t2_q)) * PT_A + ADDR_W'(pc_q)) * SQ_A
                   + ADDR_W'(to_q)) << 1) | ADDR_W'(1);
    dsq          = 14'(depth_q) * 14'(depth_q);
    bonus_c      = 16'(bonus_base) + signed'(16'(dsq));
    bonus_lim    = (bonus_c > 16'(mhg_pkg::BONUS_CAP)) ? 16'(mhg_pkg::BONUS_CAP) : bonus_c;
    malus_c      = 16'(malus_base) - signed'(16'(depth_q));
  end

  // Table memories and shared update unit
  mhg_pkg::mem_req_t       req;
  logic [ADDR_W-1:0]       req_addr;
  logic [ENTRY_BITS-1:0]   rdata;
  logic                    tbl_ready;
  logic                    unit_valid;
  logic signed [ENTRY_BITS-1:0] unit_result;
  mhg_pkg::cfg_t           cfg;

  assign cfg.bonus_shift   = bonus_shift;
  assign cfg.gravity_shift = gravity_shift;
  assign cfg.entry_limit   = entry_limit;

  mhg_tables #(
    .MAIN_DEPTH (MAIN_DEPTH),
    .CAPT_DEPTH (CAPT_DEPTH),
    .CONT_DEPTH (CONT_DEPTH),
    .ENTRY_BITS (ENTRY_BITS),
    .ADDR_W     (ADDR_W)
  ) u_tables (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .addr  (req_addr),
    .wdata (unit_result),
    .rdata (rdata),
    .ready (tbl_ready)
  );

  mhg_update #(
    .ENTRY_BITS (ENTRY_BITS)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .in_valid  ((state == S_DATA) && upd_q),
    .entry     (signed'(rdata)),
    .weight    (weight_q),
    .cfg       (cfg),
    .out_valid (unit_valid),
    .result    (unit_result)
  );

  // Memory request for the current step
  always_comb begin
    req.rd = (state == S_READ);
    req.wr = (state == S_CALC) && unit_valid;
    unique case (step)
      STEP_MAIN: begin
        req.sel  = capt_q ? mhg_pkg::TBL_CAPT : mhg_pkg::TBL_MAIN;
        req_addr = capt_q ? capt_addr : main_addr;
      end
      STEP_CONT1: begin
        req.sel  = mhg_pkg::TBL_CONT;
        req_addr = cont1_addr;
      end
      default: begin
        req.sel  = mhg_pkg::TBL_CONT;
        req_addr = cont2_addr;
      end
    endcase
  end

  // Step completion and what follows
  logic                         step_end, go_cont1, go_cont2;
  logic signed [ENTRY_BITS-1:0] step_val;

  always_comb begin
    step_end = ((state == S_DATA) && !upd_q) || ((state == S_CALC) && unit_valid);
    go_cont1 = (step == STEP_MAIN) && !capt_q && has1_q;
    go_cont2 = ((step == STEP_MAIN) && !capt_q && !has1_q && has2_q) ||
               ((step == STEP_CONT1) && has2_q);
    step_val = upd_q ? unit_result : signed'(rdata);
  end

  assign busy = (state != S_IDLE);

  // Sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step  <= STEP_MAIN;
      done  <= 1'b0;
    end else begin
      done <= step_end && !go_cont1 && !go_cont2;
      unique case (state)
        S_CLEAR: if (tbl_ready) state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            state       <= S_ADDR;
            capt_q      <= dec_capt;
            upd_q       <= dec_upd;
            bonus_q     <= dec_bonus;
            has1_q      <= {2'b00, prev1_piece} < PT_LIM;
            has2_q      <= {2'b00, prev2_piece} < PT_LIM;
            side_q      <= side;
            from_q      <= 6'(mhg_pkg::reduce(9'(from_sq), SQ_M));
            to_q        <= 6'(mhg_pkg::reduce(9'(to_sq), SQ_M));
            t1_q        <= 6'(mhg_pkg::reduce(9'(prev1_to), SQ_M));
            t2_q        <= 6'(mhg_pkg::reduce(9'(prev2_to), SQ_M));
            pc_q        <= 3'(mhg_pkg::reduce(9'(piece), PT_M));
            vc_q        <= 3'(mhg_pkg::reduce(9'(victim), PT_M));
            p1_q        <= prev1_piece;
            p2_q        <= prev2_piece;
            depth_q     <= depth;
            cont1_value <= '0;
            cont2_value <= '0;
          end
        end
        S_ADDR: begin
          state      <= S_READ;
          step       <= STEP_MAIN;
          main_addr  <= main_addr_c;
          capt_addr  <= capt_addr_c;
          cont1_addr <= cont1_addr_c;
          cont2_addr <= cont2_addr_c;
          weight_q   <= WGT_W'(bonus_q ? bonus_lim : malus_c);
        end
        S_READ: state <= S_DATA;
        S_DATA: if (upd_q) state <= S_CALC;
        S_CALC: ;
        default: state <= S_IDLE;
      endcase

      // Finished entry: store its value and pick the next one
      if (step_end) begin
        unique case (step)
          STEP_MAIN:  main_value  <= OUT_W'(step_val);
          STEP_CONT1: cont1_value <= OUT_W'(step_val);
          default:    cont2_value <= OUT_W'(step_val);
        endcase
        if (go_cont1) begin
          step  <= STEP_CONT1;
          state <= S_READ;
        end else if (go_cont2) begin
          step  <= STEP_CONT2;
          state <= S_READ;
        end else begin
          state <= S_IDLE;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/mhg_checker.sv =====
// ----------------------------------------------------------------------------
// mhg_checker
// Port-level checks of the command sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module mhg_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // An accepted command makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // A result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without preceding work");

  // The result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // The block is free again in the cycle its result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy high while result is shown");

endmodule

bind move_history_gravity_tables mhg_checker u_mhg_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
